[hw/rtl/w5d_pkg.sv]
// ----------------------------------------------------------------------------
// w5d_pkg
// Shared widths and constants of the WENO5 derivative datapath.
// ----------------------------------------------------------------------------
package w5d_pkg;

  // Normalized samples are scaled so the largest magnitude has this many bits.
  localparam int NORM_BITS = 15;
  localparam int B_W       = 16;  // normalized sample, signed
  localparam int MB_W      = 16;  // magnitude of a normalized sample
  localparam int T_W       = 20;  // indicator terms, signed
  localparam int SQ_W      = 38;  // squared indicator term
  localparam int MSQ_W     = 31;  // largest squared sample
  localparam int S_W       = 40;  // smoothness indicator (scaled by 12)
  localparam int EPS_MUL_W = 24;
  localparam logic [EPS_MUL_W-1:0] EPS_MUL = 24'd13194140;
  localparam int EPS_SHIFT = 40;
  localparam int EPSP_W    = 55;
  localparam int RHO_BITS  = 15;
  localparam int RHO_W     = 16;  // ratio Smin/S, up to 2^15
  localparam int RSQ_W     = 31;  // squared ratio
  localparam int AL_W      = 34;  // weighted ratio and their sum
  localparam int LANES     = 3;   // candidate stencils

  // Constant divide by three, one byte per step.
  localparam int DIG_W        = 8;
  localparam int RECIP3_W     = 10;
  localparam logic [RECIP3_W-1:0] RECIP3 = 10'd683;
  localparam int RECIP3_SHIFT = 11;

  // Fraction bits of the normalized weights.
  function automatic int weight_frac(input int dw);
    return ((58 - dw) < 30) ? (58 - dw) : 30;
  endfunction

endpackage

[hw/rtl/w5d_front.sv]
// ----------------------------------------------------------------------------
// w5d_front
// Normalizes the five differences, forms the candidate numerators and the
// three smoothness indicators with epsilon; nine register stages.
// ----------------------------------------------------------------------------
module w5d_front #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [4:0][DATA_WIDTH-1:0]            a,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0][w5d_pkg::S_W-1:0]          s,
  output logic [w5d_pkg::S_W-1:0]               smin,
  output logic [2:0][DATA_WIDTH+4:0]            n
);
  import w5d_pkg::*;

  localparam int N_W   = DATA_WIDTH + 5;
  localparam int LEN_W = $clog2(DATA_WIDTH + 1);
  localparam int NST   = 9;

  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  assign en[NST] = out_ready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = ~v_r[i] | en[i+1];
  end
  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 0: capture
  logic signed [DATA_WIDTH-1:0] a0_r [5];
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 5; i++) a0_r[i] <= $signed(a[i]);
    end
  end

  // stage 1: largest magnitude, candidate numerators
  logic signed [N_W-1:0]        e [5];
  logic [DATA_WIDTH-1:0]        mag [5];
  logic [DATA_WIDTH-1:0]        m_nxt;
  logic signed [N_W-1:0]        n_nxt [3];
  logic signed [DATA_WIDTH-1:0] a1_r [5];
  logic [DATA_WIDTH-1:0]        m1_r;
  logic signed [N_W-1:0]        n1_r [3];

  always_comb begin
    m_nxt = '0;
    for (int i = 0; i < 5; i++) begin
      e[i]   = N_W'(a0_r[i]);
      mag[i] = a0_r[i][DATA_WIDTH-1] ? DATA_WIDTH'(-a0_r[i]) : DATA_WIDTH'(a0_r[i]);
      if (mag[i] > m_nxt) m_nxt = mag[i];
    end
    n_nxt[0] = (e[0] <<< 1) - ((e[1] <<< 3) - e[1]) + ((e[2] <<< 3) + (e[2] <<< 1) + e[2]);
    n_nxt[1] = ((e[2] <<< 2) + e[2]) + (e[3] <<< 1) - e[1];
    n_nxt[2] = (e[2] <<< 1) + ((e[3] <<< 2) + e[3]) - e[4];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      a1_r <= a0_r;
      m1_r <= m_nxt;
      n1_r <= n_nxt;
    end
  end

  // stage 2: bit length of the largest magnitude
  logic [LEN_W-1:0]             len_nxt;
  logic signed [DATA_WIDTH-1:0] a2_r [5];
  logic [LEN_W-1:0]             len2_r;
  logic signed [N_W-1:0]        n2_r [3];

  always_comb begin
    len_nxt = '0;
    for (int i = 0; i < DATA_WIDTH; i++) begin
      if (m1_r[i]) len_nxt = LEN_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      a2_r   <= a1_r;
      len2_r <= len_nxt;
      n2_r   <= n1_r;
    end
  end

  // stage 3: scale so the largest sample has NORM_BITS bits
  logic signed [DATA_WIDTH-1:0] shd [5];
  logic signed [B_W-1:0]        b3_r [5];
  logic signed [N_W-1:0]        n3_r [3];

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      if (len2_r > LEN_W'(NORM_BITS)) begin
        shd[i] = a2_r[i] >>> (len2_r - LEN_W'(NORM_BITS));
      end else if (len2_r != '0) begin
        shd[i] = a2_r[i] <<< (LEN_W'(NORM_BITS) - len2_r);
      end else begin
        shd[i] = a2_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 5; i++) b3_r[i] <= $signed(shd[i][B_W-1:0]);
      n3_r <= n2_r;
    end
  end

  // stage 4: indicator terms, largest normalized magnitude
  logic signed [T_W-1:0] bx [5];
  logic signed [T_W-1:0] t1_nxt [3];
  logic signed [T_W-1:0] t2_nxt [3];
  logic [MB_W-1:0]       bm [5];
  logic [MB_W-1:0]       maxb_nxt;
  logic signed [T_W-1:0] t1_4_r [3];
  logic signed [T_W-1:0] t2_4_r [3];
  logic [MB_W-1:0]       maxb4_r;
  logic signed [N_W-1:0] n4_r [3];

  always_comb begin
    maxb_nxt = '0;
    for (int i = 0; i < 5; i++) begin
      bx[i] = T_W'(b3_r[i]);
      bm[i] = b3_r[i][B_W-1] ? MB_W'(-b3_r[i]) : MB_W'(b3_r[i]);
      if (bm[i] > maxb_nxt) maxb_nxt = bm[i];
    end
    t1_nxt[0] = bx[0] - (bx[1] <<< 1) + bx[2];
    t2_nxt[0] = bx[0] - (bx[1] <<< 2) + ((bx[2] <<< 1) + bx[2]);
    t1_nxt[1] = bx[1] - (bx[2] <<< 1) + bx[3];
    t2_nxt[1] = bx[1] - bx[3];
    t1_nxt[2] = bx[2] - (bx[3] <<< 1) + bx[4];
    t2_nxt[2] = ((bx[2] <<< 1) + bx[2]) - (bx[3] <<< 2) + bx[4];
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      t1_4_r  <= t1_nxt;
      t2_4_r  <= t2_nxt;
      maxb4_r <= maxb_nxt;
      n4_r    <= n3_r;
    end
  end

  // stage 5: squares
  logic [2*T_W-1:0]      u1 [3];
  logic [2*T_W-1:0]      u2 [3];
  logic [2*T_W-1:0]      p1 [3];
  logic [2*T_W-1:0]      p2 [3];
  logic [2*MB_W-1:0]     mbx;
  logic [2*MB_W-1:0]     mbsq;
  logic [SQ_W-1:0]       sq1_5_r [3];
  logic [SQ_W-1:0]       sq2_5_r [3];
  logic [MSQ_W-1:0]      msq5_r;
  logic signed [N_W-1:0] n5_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      u1[k] = (2*T_W)'(t1_4_r[k][T_W-1] ? T_W'(-t1_4_r[k]) : T_W'(t1_4_r[k]));
      u2[k] = (2*T_W)'(t2_4_r[k][T_W-1] ? T_W'(-t2_4_r[k]) : T_W'(t2_4_r[k]));
      p1[k] = u1[k] * u1[k];
      p2[k] = u2[k] * u2[k];
    end
    mbx  = (2*MB_W)'(maxb4_r);
    mbsq = mbx * mbx;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int k = 0; k < 3; k++) begin
        sq1_5_r[k] <= p1[k][SQ_W-1:0];
        sq2_5_r[k] <= p2[k][SQ_W-1:0];
      end
      msq5_r <= mbsq[MSQ_W-1:0];
      n5_r   <= n4_r;
    end
  end

  // stage 6: 13*t1^2 + 3*t2^2, epsilon product
  logic [S_W-1:0]        x1 [3];
  logic [S_W-1:0]        x2 [3];
  logic [S_W-1:0]        sraw_nxt [3];
  logic [EPSP_W-1:0]     mx;
  logic [EPSP_W-1:0]     epsp_nxt;
  logic [S_W-1:0]        sraw6_r [3];
  logic [EPSP_W-1:0]     epsp6_r;
  logic signed [N_W-1:0] n6_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      x1[k] = S_W'(sq1_5_r[k]);
      x2[k] = S_W'(sq2_5_r[k]);
      sraw_nxt[k] = (x1[k] << 3) + (x1[k] << 2) + x1[k] + (x2[k] << 1) + x2[k];
    end
    mx       = EPSP_W'(msq5_r);
    epsp_nxt = mx * EPSP_W'(EPS_MUL);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      sraw6_r <= sraw_nxt;
      epsp6_r <= epsp_nxt;
      n6_r    <= n5_r;
    end
  end

  // stage 7: add epsilon, which is at least one LSB
  logic [S_W-1:0]        eps;
  logic [S_W-1:0]        s7_r [3];
  logic signed [N_W-1:0] n7_r [3];

  assign eps = S_W'(epsp6_r >> EPS_SHIFT) + S_W'(1);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int k = 0; k < 3; k++) s7_r[k] <= sraw6_r[k] + eps;
      n7_r <= n6_r;
    end
  end

  // stage 8: smallest indicator
  logic [S_W-1:0]        smin_nxt;
  logic [S_W-1:0]        s8_r [3];
  logic [S_W-1:0]        smin8_r;
  logic signed [N_W-1:0] n8_r [3];

  always_comb begin
    smin_nxt = s7_r[0];
    for (int k = 1; k < 3; k++) begin
      if (s7_r[k] < smin_nxt) smin_nxt = s7_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_r    <= s7_r;
      smin8_r <= smin_nxt;
      n8_r    <= n7_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s[k] = s8_r[k];
      n[k] = n8_r[k];
    end
  end
  assign smin = smin8_r;

endmodule

[hw/rtl/w5d_div.sv]
// ----------------------------------------------------------------------------
// w5d_div
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// Computes floor(num * 2^(Q_BITS-1) / den) for num <= den.
// ----------------------------------------------------------------------------
module w5d_div #(
  parameter int D_W    = 40,
  parameter int Q_BITS = 16,
  parameter int SIDE_W = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic [w5d_pkg::LANES-1:0][D_W-1:0]       num,
  input  logic [w5d_pkg::LANES-1:0][D_W-1:0]       den,
  input  logic [SIDE_W-1:0]                        side_in,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [w5d_pkg::LANES-1:0][Q_BITS-1:0]    quo,
  output logic [SIDE_W-1:0]                        side_out
);
  import w5d_pkg::*;

  logic [Q_BITS-1:0] v_r;
  logic [Q_BITS:0]   en;
  logic [D_W-1:0]    rem_r [Q_BITS][LANES];
  logic [D_W-1:0]    dv_r  [Q_BITS][LANES];
  logic [Q_BITS-1:0] q_r   [Q_BITS][LANES];
  logic [SIDE_W-1:0] sd_r  [Q_BITS];

  assign en[Q_BITS] = out_ready;
  assign in_ready   = en[0];
  assign out_valid  = v_r[Q_BITS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int j = 1; j < Q_BITS; j++) begin
        if (en[j]) v_r[j] <= v_r[j-1];
      end
    end
  end

  for (genvar j = 0; j < Q_BITS; j++) begin : g_stage
    assign en[j] = ~v_r[j] | en[j+1];

    for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic [D_W:0]      x;
      logic [D_W-1:0]    d;
      logic [Q_BITS-1:0] qp;
      logic [D_W:0]      diff;
      logic              ge;

      if (j == 0) begin : g_first
        assign x  = {1'b0, num[k]};
        assign d  = den[k];
        assign qp = '0;
      end else begin : g_next
        assign x  = {rem_r[j-1][k], 1'b0};
        assign d  = dv_r[j-1][k];
        assign qp = q_r[j-1][k];
      end

      assign ge   = x >= {1'b0, d};
      assign diff = x - {1'b0, d};

      // partial remainder stays below the divisor
      always_ff @(posedge clk) begin
        if (en[j]) begin
          rem_r[j][k] <= ge ? diff[D_W-1:0] : x[D_W-1:0];
          dv_r[j][k]  <= d;
          q_r[j][k]   <= {qp[Q_BITS-2:0], ge};
        end
      end
    end

    if (j == 0) begin : g_side_first
      always_ff @(posedge clk) begin
        if (en[j]) sd_r[j] <= side_in;
      end
    end else begin : g_side_next
      always_ff @(posedge clk) begin
        if (en[j]) sd_r[j] <= sd_r[j-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) quo[k] = q_r[Q_BITS-1][k];
  end
  assign side_out = sd_r[Q_BITS-1];

endmodule

[hw/rtl/w5d_mid.sv]
// ----------------------------------------------------------------------------
// w5d_mid
// Unnormalized weights c_k * rho_k^2 (c = 1, 6, 3) and their sum.
// ----------------------------------------------------------------------------
module w5d_mid #(
  parameter int SIDE_W = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [2:0][w5d_pkg::RHO_W-1:0]        rho,
  input  logic [SIDE_W-1:0]                     side_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0][w5d_pkg::AL_W-1:0]         alpha,
  output logic [w5d_pkg::AL_W-1:0]              dsum,
  output logic [SIDE_W-1:0]                     side_out
);
  import w5d_pkg::*;

  localparam int NST = 3;

  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  assign en[NST] = out_ready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = ~v_r[i] | en[i+1];
  end
  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 0: square the ratios
  logic [2*RHO_W-1:0] rx [3];
  logic [2*RHO_W-1:0] rp [3];
  logic [RSQ_W-1:0]   rsq0_r [3];
  logic [SIDE_W-1:0]  sd0_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rx[k] = (2*RHO_W)'(rho[k]);
      rp[k] = rx[k] * rx[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) rsq0_r[k] <= rp[k][RSQ_W-1:0];
      sd0_r <= side_in;
    end
  end

  // stage 1: apply the linear weights 1, 6, 3
  logic [AL_W-1:0]   ex [3];
  logic [AL_W-1:0]   al1_r [3];
  logic [SIDE_W-1:0] sd1_r;

  always_comb begin
    for (int k = 0; k < 3; k++) ex[k] = AL_W'(rsq0_r[k]);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      al1_r[0] <= ex[0];
      al1_r[1] <= (ex[1] << 2) + (ex[1] << 1);
      al1_r[2] <= (ex[2] << 1) + ex[2];
      sd1_r    <= sd0_r;
    end
  end

  // stage 2: denominator
  logic [AL_W-1:0]   al2_r [3];
  logic [AL_W-1:0]   d2_r;
  logic [SIDE_W-1:0] sd2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      al2_r <= al1_r;
      d2_r  <= al1_r[0] + al1_r[1] + al1_r[2];
      sd2_r <= sd1_r;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) alpha[k] = al2_r[k];
  end
  assign dsum     = d2_r;
  assign side_out = sd2_r;

endmodule

[hw/rtl/w5d_back.sv]
// ----------------------------------------------------------------------------
// w5d_back
// Weighted sum of the candidates, round half up, divide by six and saturate.
// The last stage is the output register.
// ----------------------------------------------------------------------------
module w5d_back #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  in_valid,
  output logic                                                  in_ready,
  input  logic [2:0][w5d_pkg::weight_frac(DATA_WIDTH):0]        w,
  input  logic [2:0][DATA_WIDTH+4:0]                            n,
  output logic                                                  out_valid,
  input  logic                                                  out_ready,
  output logic [DATA_WIDTH-1:0]                                 res
);
  import w5d_pkg::*;

  localparam int W     = weight_frac(DATA_WIDTH);
  localparam int WQ_W  = W + 1;
  localparam int N_W   = DATA_WIDTH + 5;
  localparam int LO_W  = (N_W + 1) / 2;
  localparam int HI_W  = N_W - LO_W;
  localparam int PL_W  = WQ_W + LO_W;
  localparam int PH_W  = WQ_W + 1 + HI_W;
  localparam int ACC_W = W + DATA_WIDTH + 7;
  localparam int Y_W   = ACC_W - W;
  localparam int H_W   = Y_W - 1;
  localparam int NDIG  = (H_W + DIG_W - 1) / DIG_W;
  localparam int HP_W  = NDIG * DIG_W;
  localparam int NLO   = NDIG / 2;
  localparam int LO_B  = NLO * DIG_W;
  localparam int QH_W  = HP_W - LO_B;
  localparam int X_W   = DIG_W + 2;
  localparam int XP_W  = X_W + RECIP3_W;
  localparam int NST   = 7;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(3) <<< W;
  localparam logic signed [Y_W-1:0] SAT_HI =
    {{(Y_W-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [Y_W-1:0] SAT_LO =
    {{(Y_W-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  logic [NST-1:0] v_r;
  logic [NST:0]   en;

  assign en[NST] = out_ready;
  for (genvar i = 0; i < NST; i++) begin : g_en
    assign en[i] = ~v_r[i] | en[i+1];
  end
  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  // stage 0: weight times numerator, split into low and high halves
  logic [PL_W-1:0]        wl [3];
  logic [PL_W-1:0]        ll [3];
  logic signed [PH_W-1:0] ws [3];
  logic signed [PH_W-1:0] hs [3];
  logic [PL_W-1:0]        pl0_r [3];
  logic signed [PH_W-1:0] ph0_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wl[k] = PL_W'(w[k]);
      ll[k] = PL_W'(n[k][LO_W-1:0]);
      ws[k] = PH_W'($signed({1'b0, w[k]}));
      hs[k] = PH_W'($signed(n[k][N_W-1:LO_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        pl0_r[k] <= wl[k] * ll[k];
        ph0_r[k] <= ws[k] * hs[k];
      end
    end
  end

  // stage 1: recombine halves
  logic signed [ACC_W-1:0] phx [3];
  logic signed [ACC_W-1:0] plx [3];
  logic signed [ACC_W-1:0] p1_r [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      phx[k] = ACC_W'(ph0_r[k]);
      plx[k] = $signed(ACC_W'(pl0_r[k]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) p1_r[k] <= (phx[k] <<< LO_W) + plx[k];
    end
  end

  // stage 2: accumulate with half of the final divisor
  logic signed [ACC_W-1:0] acc2_r;

  always_ff @(posedge clk) begin
    if (en[2]) acc2_r <= p1_r[0] + p1_r[1] + p1_r[2] + RND;
  end

  // stage 3: drop weight fraction, fold sign for floor division by six
  logic [Y_W-1:0] ybits;
  logic           yneg;
  logic [Y_W-1:0] ymag;
  logic [H_W-1:0] h3_r;
  logic           neg3_r;

  always_comb begin
    ybits = acc2_r[ACC_W-1:W];
    yneg  = ybits[Y_W-1];
    // floor(y/6) = -floor((5-y)/6) for negative y
    ymag  = yneg ? (~ybits + Y_W'(6)) : ybits;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      h3_r   <= ymag[Y_W-1:1];
      neg3_r <= yneg;
    end
  end

  // stage 4: divide by three, upper bytes
  logic [HP_W-1:0]  hp;
  logic [QH_W-1:0]  qh;
  logic [1:0]       rm;
  logic [X_W-1:0]   xd;
  logic [XP_W-1:0]  xp;
  logic [DIG_W-1:0] qd;
  logic [X_W-1:0]   q3;
  logic [QH_W-1:0]  qh4_r;
  logic [LO_B-1:0]  hl4_r;
  logic [1:0]       rm4_r;
  logic             neg4_r;

  always_comb begin
    hp = HP_W'(h3_r);
    qh = '0;
    rm = '0;
    xd = '0;
    xp = '0;
    qd = '0;
    q3 = '0;
    for (int d = NDIG - 1; d >= NLO; d--) begin
      xd = {rm, hp[d*DIG_W +: DIG_W]};
      xp = XP_W'(xd) * XP_W'(RECIP3);
      qd = xp[RECIP3_SHIFT +: DIG_W];
      q3 = (X_W'(qd) << 1) + X_W'(qd);
      rm = 2'(xd - q3);
      qh[(d-NLO)*DIG_W +: DIG_W] = qd;
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      qh4_r  <= qh;
      hl4_r  <= hp[LO_B-1:0];
      rm4_r  <= rm;
      neg4_r <= neg3_r;
    end
  end

  // stage 5: divide by three, lower bytes
  logic [LO_B-1:0]  ql;
  logic [1:0]       rl;
  logic [X_W-1:0]   xl;
  logic [XP_W-1:0]  xlp;
  logic [DIG_W-1:0] qdl;
  logic [X_W-1:0]   q3l;
  logic [H_W-1:0]   qm5_r;
  logic             neg5_r;

  always_comb begin
    ql  = '0;
    rl  = rm4_r;
    xl  = '0;
    xlp = '0;
    qdl = '0;
    q3l = '0;
    for (int d = NLO - 1; d >= 0; d--) begin
      xl  = {rl, hl4_r[d*DIG_W +: DIG_W]};
      xlp = XP_W'(xl) * XP_W'(RECIP3);
      qdl = xlp[RECIP3_SHIFT +: DIG_W];
      q3l = (X_W'(qdl) << 1) + X_W'(qdl);
      rl  = 2'(xl - q3l);
      ql[d*DIG_W +: DIG_W] = qdl;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      qm5_r  <= H_W'({qh4_r, ql});
      neg5_r <= neg4_r;
    end
  end

  // stage 6: restore sign, saturate, output register
  logic signed [Y_W-1:0]  qs;
  logic [DATA_WIDTH-1:0]  res_nxt;
  logic [DATA_WIDTH-1:0]  res6_r;

  always_comb begin
    qs = neg5_r ? -$signed(Y_W'(qm5_r)) : $signed(Y_W'(qm5_r));
    if (qs > SAT_HI) begin
      res_nxt = SAT_HI[DATA_WIDTH-1:0];
    end else if (qs < SAT_LO) begin
      res_nxt = SAT_LO[DATA_WIDTH-1:0];
    end else begin
      res_nxt = qs[DATA_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) res6_r <= res_nxt;
  end

  assign res = res6_r;

endmodule

[hw/rtl/weno5_derivative_unit.sv]
// ----------------------------------------------------------------------------
// weno5_derivative_unit
// Fifth-order WENO derivative from five one-sided differences, signed Q16.16.
// Two pipelined dividers set the depth; W = min(30, 58 - DATA_WIDTH).
// Throughput: one item per cycle while out_stall is low.
// Reset: synchronous, active low; clears all stage valid bits only.
// ----------------------------------------------------------------------------
module weno5_derivative_unit #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] in_diff_m2,
  input  logic signed [DATA_WIDTH-1:0] in_diff_m1,
  input  logic signed [DATA_WIDTH-1:0] in_diff_c0,
  input  logic signed [DATA_WIDTH-1:0] in_diff_p1,
  input  logic signed [DATA_WIDTH-1:0] in_diff_p2,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] out_derivative
);
  import w5d_pkg::*;

  // Datapath, in order:
  //   front : 9 stages  - normalize, numerators, indicators + epsilon, minimum
  //   div1  : 16 stages - rho_k = Smin * 2^15 / S_k, one bit per stage
  //   mid   : 3 stages  - alpha_k = c_k * rho_k^2 and their sum D
  //   div2  : W+1       - w_k = alpha_k * 2^W / D
  //   back  : 7 stages  - weighted sum, round, divide by six, saturate
  // Every stage holds its own valid bit and advances when the stage after it
  // is empty or advancing, so bubbles collapse and a stall drops nothing.

  localparam int W      = weight_frac(DATA_WIDTH);
  localparam int N_W    = DATA_WIDTH + 5;
  localparam int SIDE_W = 3 * N_W;

  logic                       fr_ready;
  logic                       fr_valid;
  logic [2:0][S_W-1:0]        fr_s;
  logic [S_W-1:0]             fr_smin;
  logic [2:0][N_W-1:0]        fr_n;

  logic                       d1_ready;
  logic                       d1_valid;
  logic [2:0][RHO_W-1:0]      d1_rho;
  logic [SIDE_W-1:0]          d1_side;

  logic                       md_ready;
  logic                       md_valid;
  logic [2:0][AL_W-1:0]       md_alpha;
  logic [AL_W-1:0]            md_dsum;
  logic [SIDE_W-1:0]          md_side;

  logic                       d2_ready;
  logic                       d2_valid;
  logic [2:0][W:0]            d2_w;
  logic [SIDE_W-1:0]          d2_side;

  logic                       bk_ready;

  // Stall the source whenever the first stage cannot take an item.
  assign in_stall = ~fr_ready;

  w5d_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (fr_ready),
    .a        ({in_diff_p2, in_diff_p1, in_diff_c0, in_diff_m1, in_diff_m2}),
    .out_valid(fr_valid),
    .out_ready(d1_ready),
    .s        (fr_s),
    .smin     (fr_smin),
    .n        (fr_n)
  );

  // Ratios of the smallest indicator to each indicator; Smin <= S_k.
  w5d_div #(
    .D_W   (S_W),
    .Q_BITS(RHO_BITS + 1),
    .SIDE_W(SIDE_W)
  ) u_div_rho (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (fr_valid),
    .in_ready (d1_ready),
    .num      ({3{fr_smin}}),
    .den      (fr_s),
    .side_in  (fr_n),
    .out_valid(d1_valid),
    .out_ready(md_ready),
    .quo      (d1_rho),
    .side_out (d1_side)
  );

  w5d_mid #(
    .SIDE_W(SIDE_W)
  ) u_mid (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (d1_valid),
    .in_ready (md_ready),
    .rho      (d1_rho),
    .side_in  (d1_side),
    .out_valid(md_valid),
    .out_ready(d2_ready),
    .alpha    (md_alpha),
    .dsum     (md_dsum),
    .side_out (md_side)
  );

  // Normalized weights; alpha_k <= D, and D >= 2^30.
  w5d_div #(
    .D_W   (AL_W),
    .Q_BITS(W + 1),
    .SIDE_W(SIDE_W)
  ) u_div_w (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (md_valid),
    .in_ready (d2_ready),
    .num      (md_alpha),
    .den      ({3{md_dsum}}),
    .side_in  (md_side),
    .out_valid(d2_valid),
    .out_ready(bk_ready),
    .quo      (d2_w),
    .side_out (d2_side)
  );

  // The last back stage is the output register; hold it while stalled.
  w5d_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (d2_valid),
    .in_ready (bk_ready),
    .w        (d2_w),
    .n        (d2_side),
    .out_valid(out_valid),
    .out_ready(~out_stall),
    .res      (out_derivative)
  );

endmodule
